// ===== rtl/core/mbrs_pkg.sv =====
package mbrs_pkg;

    // Outcome of the frame decode.
    localparam logic [1:0] RESP_DROP  = 2'd0;
    localparam logic [1:0] RESP_READ  = 2'd1;
    localparam logic [1:0] RESP_WRITE = 2'd2;
    localparam logic [1:0] RESP_EXC   = 2'd3;

    // Function codes and exception codes.
    localparam logic [7:0] FN_READ_HOLD  = 8'h03;
    localparam logic [7:0] FN_READ_INPUT = 8'h04;
    localparam logic [7:0] FN_WRITE_MULT = 8'h10;
    localparam logic [7:0] FN_EXC_FLAG   = 8'h80;
    localparam logic [7:0] EXC_FUNCTION  = 8'h01;
    localparam logic [7:0] EXC_ADDRESS   = 8'h02;
    localparam logic [7:0] EXC_VALUE     = 8'h03;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Response byte selection.
    localparam logic [3:0] SEL_ADDR    = 4'd0;
    localparam logic [3:0] SEL_FN      = 4'd1;
    localparam logic [3:0] SEL_FN_EXC  = 4'd2;
    localparam logic [3:0] SEL_B2      = 4'd3;
    localparam logic [3:0] SEL_H3      = 4'd4;
    localparam logic [3:0] SEL_H4      = 4'd5;
    localparam logic [3:0] SEL_H5      = 4'd6;
    localparam logic [3:0] SEL_RD_HI   = 4'd7;
    localparam logic [3:0] SEL_RD_LO   = 4'd8;
    localparam logic [3:0] SEL_CRC_LO  = 4'd9;
    localparam logic [3:0] SEL_CRC_HI  = 4'd10;

    typedef struct packed {
        logic       acc_link;
        logic       acc_local;
        logic       frame_end;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       hdr_phase;
        logic       wr_phase;
        logic       rf_rd;
        logic       crc_init;
        logic       emit;
        logic [3:0] sel;
        logic       last;
    } mbrs_cmd_t;

    typedef struct packed {
        logic [1:0] resp;
        logic       hdr_done;
        logic       wr_done;
        logic       rd_last;
        logic       num_zero;
        logic       tx_free;
    } mbrs_stat_t;

    // One byte of the reflected CRC-16.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mbrs_ctrl.sv =====
module mbrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_kind,
    input  logic                in_last,
    output logic                in_ready,
    input  mbrs_pkg::mbrs_stat_t stat,
    output mbrs_pkg::mbrs_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HDR    = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_WR     = 4'd3;
    localparam logic [3:0] S_E_ADDR = 4'd4;
    localparam logic [3:0] S_E_FN   = 4'd5;
    localparam logic [3:0] S_E_B2   = 4'd6;
    localparam logic [3:0] S_E_H3   = 4'd7;
    localparam logic [3:0] S_E_H4   = 4'd8;
    localparam logic [3:0] S_E_H5   = 4'd9;
    localparam logic [3:0] S_RD_FET = 4'd10;
    localparam logic [3:0] S_RD_HI  = 4'd11;
    localparam logic [3:0] S_RD_LO  = 4'd12;
    localparam logic [3:0] S_CRC_LO = 4'd13;
    localparam logic [3:0] S_CRC_HI = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind)
                    begin
                        cmd.acc_local = 1'b1;
                    end
                    else
                    begin
                        cmd.acc_link = 1'b1;
                        if (in_last)
                        begin
                            cmd.frame_end = 1'b1;
                            cmd.cnt_clr   = 1'b1;
                            state_next    = S_HDR;
                        end
                    end
                end
            end
            S_HDR:
            begin
                cmd.hdr_phase = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (stat.hdr_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.cnt_clr  = 1'b1;
                cmd.crc_init = 1'b1;
                case (stat.resp)
                    mbrs_pkg::RESP_DROP:  state_next = S_IDLE;
                    mbrs_pkg::RESP_WRITE: state_next = S_WR;
                    default:              state_next = S_E_ADDR;
                endcase
            end
            S_WR:
            begin
                cmd.wr_phase = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (stat.wr_done)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_E_ADDR;
                end
            end
            S_E_ADDR:
            begin
                cmd.sel = mbrs_pkg::SEL_ADDR;
                if (stat.tx_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_E_FN;
                end
            end
            S_E_FN:
            begin
                cmd.sel = (stat.resp == mbrs_pkg::RESP_EXC) ? mbrs_pkg::SEL_FN_EXC
                                                            : mbrs_pkg::SEL_FN;
                if (stat.tx_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_E_B2;
                end
            end
            S_E_B2:
            begin
                cmd.sel = mbrs_pkg::SEL_B2;
                if (stat.tx_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.resp == mbrs_pkg::RESP_READ)
                    begin
                        state_next = stat.num_zero ? S_CRC_LO : S_RD_FET;
                    end
                    else if (stat.resp == mbrs_pkg::RESP_WRITE)
                    begin
                        state_next = S_E_H3;
                    end
                    else
                    begin
                        state_next = S_CRC_LO;
                    end
                end
            end
            S_E_H3:
            begin
                cmd.sel = mbrs_pkg::SEL_H3;
                if (stat.tx_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_E_H4;
                end
            end
            S_E_H4:
            begin
                cmd.sel = mbrs_pkg::SEL_H4;
                if (stat.tx_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_E_H5;
                end
            end
            S_E_H5:
            begin
                cmd.sel = mbrs_pkg::SEL_H5;
                if (stat.tx_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_CRC_LO;
                end
            end
            S_RD_FET:
            begin
                cmd.rf_rd  = 1'b1;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                cmd.sel = mbrs_pkg::SEL_RD_HI;
                if (stat.tx_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_RD_LO;
                end
            end
            S_RD_LO:
            begin
                cmd.sel = mbrs_pkg::SEL_RD_LO;
                if (stat.tx_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.rd_last)
                    begin
                        state_next = S_CRC_LO;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_RD_FET;
                    end
                end
            end
            S_CRC_LO:
            begin
                cmd.sel = mbrs_pkg::SEL_CRC_LO;
                if (stat.tx_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_CRC_HI;
                end
            end
            S_CRC_HI:
            begin
                cmd.sel  = mbrs_pkg::SEL_CRC_HI;
                cmd.last = 1'b1;
                if (stat.tx_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/mbrs_dp.sv =====
module mbrs_dp #(
    parameter int TABLE_DEPTH = 20,
    parameter int FRAME_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbrs_pkg::mbrs_cmd_t  cmd,
    output mbrs_pkg::mbrs_stat_t stat,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic [7:0]           rx_byte,
    input  logic [1:0]           local_bank,
    input  logic [4:0]           local_index,
    input  logic [15:0]          local_value,
    output logic                 tx_valid,
    input  logic                 tx_ready,
    output logic [7:0]           tx_byte,
    output logic                 tx_last
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int LW = $clog2(FRAME_BYTES + 1);
    localparam int RD = 4 * TABLE_DEPTH;
    localparam int RW = $clog2(RD);
    localparam int CW = $clog2(2 * TABLE_DEPTH + 9);
    localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);

    logic [7:0]    slave_addr_reg;
    logic [7:0]    buf_mem [FRAME_BYTES];
    logic [7:0]    buf_q_reg;
    logic [LW-1:0] len_reg;
    logic          ovf_reg;
    logic [15:0]   crc_rx_reg;
    logic [LW-1:0] len_l_reg;
    logic          ovf_l_reg;
    logic          crc_ok_reg;
    logic [7:0]    hdr_reg [7];
    logic [7:0]    hi_reg;
    logic [CW-1:0] cnt_reg;
    logic [15:0]   rf_mem [RD];
    logic [RD-1:0] rf_vld_reg;
    logic [15:0]   rd_word_reg;
    logic [15:0]   crc_tx_reg;
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;
    logic          out_last_reg;

    logic [15:0]   crc_rx_next;
    logic [LW-1:0] len_next;
    logic          ovf_next;
    logic [15:0]   num;
    logic [3:0]    bank;
    logic [11:0]   off;
    logic [16:0]   span;
    logic [16:0]   num2;
    logic [16:0]   len17;
    logic [7:0]    exc_code;
    logic [1:0]    resp;
    logic [AW-1:0] buf_rd_addr;
    logic [CW-1:0] cnt_m1;
    logic [RW-1:0] rf_rd_addr;
    logic          rf_we;
    logic [RW-1:0] rf_wa;
    logic [15:0]   rf_wd;
    logic [7:0]    emit_byte;

    // Receive side: length, overflow and running CRC.
    assign crc_rx_next = mbrs_pkg::crc16_step(crc_rx_reg, rx_byte);
    assign ovf_next    = ovf_reg | (len_reg == LW'(FRAME_BYTES));
    assign len_next    = (len_reg == LW'(FRAME_BYTES)) ? len_reg : len_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= 8'd1;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            crc_rx_reg     <= mbrs_pkg::CRC_INIT;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                slave_addr_reg <= cfg_wr_data;
            end
            if (cmd.acc_link)
            begin
                if (cmd.frame_end)
                begin
                    len_reg    <= '0;
                    ovf_reg    <= 1'b0;
                    crc_rx_reg <= mbrs_pkg::CRC_INIT;
                end
                else
                begin
                    len_reg    <= len_next;
                    ovf_reg    <= ovf_next;
                    crc_rx_reg <= crc_rx_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_link && cmd.frame_end)
        begin
            len_l_reg  <= len_next;
            ovf_l_reg  <= ovf_next;
            crc_ok_reg <= (crc_rx_next == 16'h0000);
        end
    end

    // Frame buffer, one write and one registered read port.
    assign buf_rd_addr = cmd.wr_phase ? AW'(7 + int'(cnt_reg)) : AW'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.acc_link && (len_reg != LW'(FRAME_BYTES)))
        begin
            buf_mem[len_reg[AW-1:0]] <= rx_byte;
        end
        buf_q_reg <= buf_mem[buf_rd_addr];
    end

    // Step counter.
    assign cnt_m1 = cnt_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_phase && (cnt_reg != '0))
        begin
            hdr_reg[cnt_m1[2:0]] <= buf_q_reg;
        end
        if (cmd.wr_phase && (cnt_reg != '0) && !cnt_m1[0])
        begin
            hi_reg <= buf_q_reg;
        end
    end

    // Frame decode.
    assign num   = {hdr_reg[4], hdr_reg[5]};
    assign bank  = hdr_reg[2][7:4];
    assign off   = {hdr_reg[2][3:0], hdr_reg[3]};
    assign span  = {5'd0, off} + {1'b0, num};
    assign num2  = {num, 1'b0};
    assign len17 = 17'(len_l_reg);

    always_comb
    begin
        resp     = mbrs_pkg::RESP_EXC;
        exc_code = mbrs_pkg::EXC_FUNCTION;
        if (ovf_l_reg || (len17 < 17'd4) || (hdr_reg[0] != slave_addr_reg) || !crc_ok_reg)
        begin
            resp = mbrs_pkg::RESP_DROP;
        end
        else if ((hdr_reg[1] == mbrs_pkg::FN_READ_HOLD) ||
                 (hdr_reg[1] == mbrs_pkg::FN_READ_INPUT))
        begin
            if (len17 < 17'd8)
            begin
                resp = mbrs_pkg::RESP_DROP;
            end
            else if ({1'b0, num} > DEPTH17)
            begin
                exc_code = mbrs_pkg::EXC_VALUE;
            end
            else if ((bank > 4'd3) || (span > DEPTH17))
            begin
                exc_code = mbrs_pkg::EXC_ADDRESS;
            end
            else
            begin
                resp = mbrs_pkg::RESP_READ;
            end
        end
        else if (hdr_reg[1] == mbrs_pkg::FN_WRITE_MULT)
        begin
            if (len17 < 17'd9)
            begin
                resp = mbrs_pkg::RESP_DROP;
            end
            else if (({1'b0, num} > DEPTH17) || ({9'd0, hdr_reg[6]} != num2) ||
                     (len17 < (num2 + 17'd9)))
            begin
                exc_code = mbrs_pkg::EXC_VALUE;
            end
            else if ((bank != 4'd0) || (span > DEPTH17))
            begin
                exc_code = mbrs_pkg::EXC_ADDRESS;
            end
            else
            begin
                resp = mbrs_pkg::RESP_WRITE;
            end
        end
    end

    // Register file with per-entry valid bits standing in for the reset clear.
    assign rf_rd_addr = RW'(int'(bank[1:0]) * TABLE_DEPTH + int'(off) + int'(cnt_reg));

    always_comb
    begin
        rf_we = 1'b0;
        rf_wa = RW'(int'(off) + int'(cnt_m1[CW-1:1]));
        rf_wd = {hi_reg, buf_q_reg};
        if (cmd.acc_local)
        begin
            rf_we = (int'(local_index) < TABLE_DEPTH);
            rf_wa = RW'(int'(local_bank) * TABLE_DEPTH + int'(local_index));
            rf_wd = local_value;
        end
        else if (cmd.wr_phase && (cnt_reg != '0) && cnt_m1[0])
        begin
            rf_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg <= '0;
        end
        else if (rf_we)
        begin
            rf_vld_reg[rf_wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_wa] <= rf_wd;
        end
        if (cmd.rf_rd)
        begin
            rd_word_reg <= rf_vld_reg[rf_rd_addr] ? rf_mem[rf_rd_addr] : 16'h0000;
        end
    end

    // Response byte selection and output register.
    always_comb
    begin
        case (cmd.sel)
            mbrs_pkg::SEL_ADDR:   emit_byte = slave_addr_reg;
            mbrs_pkg::SEL_FN:     emit_byte = hdr_reg[1];
            mbrs_pkg::SEL_FN_EXC: emit_byte = hdr_reg[1] + mbrs_pkg::FN_EXC_FLAG;
            mbrs_pkg::SEL_B2:
            begin
                if (resp == mbrs_pkg::RESP_READ)
                begin
                    emit_byte = {num[6:0], 1'b0};
                end
                else if (resp == mbrs_pkg::RESP_EXC)
                begin
                    emit_byte = exc_code;
                end
                else
                begin
                    emit_byte = hdr_reg[2];
                end
            end
            mbrs_pkg::SEL_H3:     emit_byte = hdr_reg[3];
            mbrs_pkg::SEL_H4:     emit_byte = hdr_reg[4];
            mbrs_pkg::SEL_H5:     emit_byte = hdr_reg[5];
            mbrs_pkg::SEL_RD_HI:  emit_byte = rd_word_reg[15:8];
            mbrs_pkg::SEL_RD_LO:  emit_byte = rd_word_reg[7:0];
            mbrs_pkg::SEL_CRC_LO: emit_byte = crc_tx_reg[7:0];
            mbrs_pkg::SEL_CRC_HI: emit_byte = crc_tx_reg[15:8];
            default:              emit_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tx_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.crc_init)
        begin
            crc_tx_reg <= mbrs_pkg::CRC_INIT;
        end
        else if (cmd.emit && (cmd.sel != mbrs_pkg::SEL_CRC_LO) &&
                 (cmd.sel != mbrs_pkg::SEL_CRC_HI))
        begin
            crc_tx_reg <= mbrs_pkg::crc16_step(crc_tx_reg, emit_byte);
        end
        if (cmd.emit)
        begin
            out_data_reg <= emit_byte;
            out_last_reg <= cmd.last;
        end
    end

    assign tx_valid = out_valid_reg;
    assign tx_byte  = out_data_reg;
    assign tx_last  = out_last_reg;

    assign stat.resp     = resp;
    assign stat.hdr_done = (cnt_reg == CW'(7));
    assign stat.wr_done  = (17'(cnt_reg) == num2);
    assign stat.rd_last  = ((17'(cnt_reg) + 17'd1) == {1'b0, num});
    assign stat.num_zero = (num == 16'd0);
    assign stat.tx_free  = !out_valid_reg || tx_ready;

endmodule

// ===== rtl/core/modbus_rtu_register_slave_top.sv =====
// Modbus RTU slave with four banks of TABLE_DEPTH 16-bit registers.
// Input channel (s_axis): one request per accepted beat. tuser 0 carries a
// received link byte, tlast marking the final byte of a frame; tuser 1 is a
// local register write into the bank and index carried in tdata.
// Output channel (m_axis): the response frame, one byte per beat, tlast on
// the second CRC byte. The station address is written through cfg_wr_en.
// Bytes and local writes are taken one per cycle while the block is idle.
// After the last byte of a frame the block reads seven header bytes back
// from the frame buffer, decodes them, copies write data into the
// register file at one byte per cycle, then sends the response, each
// register of a read passing through a fetch state for the register file
// port. s_axis_tready stays low from the end of a frame until the final
// response byte has been loaded into the output register; a dropped frame
// frees the input once the header read-back and decode are done.
// A stalled receiver holds the current byte in the output register and the
// sequencer waits for it. Reset clears the frame state, sets the address to
// 1 and marks every register as zero through per-entry valid bits; the
// frame buffer itself needs no clearing.
module modbus_rtu_register_slave_top #(
    parameter int TABLE_DEPTH = 20,
    parameter int FRAME_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rx_byte[7:0], local_bank[9:8], local_index[14:10], local_value[30:15], zero[31]
    input  logic [31:0] s_axis_tdata,
    // kind[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);

    mbrs_pkg::mbrs_cmd_t  cmd;
    mbrs_pkg::mbrs_stat_t stat;

    mbrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mbrs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_byte     (s_axis_tdata[7:0]),
        .local_bank  (s_axis_tdata[9:8]),
        .local_index (s_axis_tdata[14:10]),
        .local_value (s_axis_tdata[30:15]),
        .tx_valid    (m_axis_tvalid),
        .tx_ready    (m_axis_tready),
        .tx_byte     (m_axis_tdata),
        .tx_last     (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // A stalled response byte stays in the output register until it is taken.
    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("response byte changed while stalled");

    // Any earlier response byte means the response is still being built.
    a_body_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open while a response is in progress");

    // The end of a frame always starts the header read-back.
    a_frame_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser && s_axis_tlast |=> !s_axis_tready)
        else $error("input not closed after end of frame");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the Modbus RTU register slave.
// Requests are queued by the stimulus process and presented by a clocked
// driver; a predictor mirrors the frame buffer, CRC and register banks, and a
// clocked monitor compares every response byte with the oldest one due.
module tb_top;

    localparam int DEPTH     = 20;
    localparam int BUF_BYTES = 256;
    localparam int IDLE_WAIT = 60;
    localparam int WD_LIMIT  = 3000;
    localparam int LONG_HOLD = 250;

    typedef struct {
        logic        kind;
        logic [7:0]  rx;
        logic        fend;
        logic [1:0]  bank;
        logic [4:0]  idx;
        logic [15:0] val;
    } req_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } resp_byte_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    modbus_rtu_register_slave_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Shadow state of the slave.
    logic [7:0]  station;
    logic [7:0]  rx_buf [BUF_BYTES];
    int          rx_len;
    logic        rx_ovf;
    logic [15:0] rx_crc;
    logic [15:0] bank_regs [4 * DEPTH];

    req_t       pending_reqs [$];
    resp_byte_t resp_due [$];
    int         errors;
    int         reqs_queued;
    bit         quiet;
    int         idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ mbrs_pkg::CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Appends the CRC to a response and files every byte as due.
    function automatic void answer(input logic [7:0] msg[$]);
        logic [15:0] crc;
        crc = mbrs_pkg::CRC_INIT;
        foreach (msg[i])
            crc = crc_byte(crc, msg[i]);
        msg.push_back(crc[7:0]);
        msg.push_back(crc[15:8]);
        foreach (msg[i])
            resp_due.push_back('{msg[i], i == msg.size() - 1});
    endfunction

    function automatic void answer_exception(input logic [7:0] fn, input logic [7:0] code);
        logic [7:0] msg[$];
        msg = '{station, fn + mbrs_pkg::FN_EXC_FLAG, code};
        answer(msg);
    endfunction

    // Decodes a completed frame against the shadow banks.
    function automatic void decode_frame(input int len, input logic ovf, input logic [15:0] crc);
        logic [7:0]  fn;
        logic [7:0]  msg[$];
        int unsigned addr, num, bnk, off;
        if (ovf || len < 4 || rx_buf[0] != station || crc != 16'h0000)
            return;
        fn = rx_buf[1];
        if (fn == mbrs_pkg::FN_READ_HOLD || fn == mbrs_pkg::FN_READ_INPUT)
        begin
            if (len < 8)
                return;
            addr = {rx_buf[2], rx_buf[3]};
            num  = {rx_buf[4], rx_buf[5]};
            if (num > DEPTH)
            begin
                answer_exception(fn, mbrs_pkg::EXC_VALUE);
                return;
            end
            bnk = addr >> 12;
            off = addr & 12'hFFF;
            if (bnk > 3 || off + num > DEPTH)
            begin
                answer_exception(fn, mbrs_pkg::EXC_ADDRESS);
                return;
            end
            msg = '{station, fn, 8'(num * 2)};
            for (int i = 0; i < num; i++)
            begin
                msg.push_back(bank_regs[bnk * DEPTH + off + i][15:8]);
                msg.push_back(bank_regs[bnk * DEPTH + off + i][7:0]);
            end
            answer(msg);
        end
        else if (fn == mbrs_pkg::FN_WRITE_MULT)
        begin
            if (len < 9)
                return;
            addr = {rx_buf[2], rx_buf[3]};
            num  = {rx_buf[4], rx_buf[5]};
            if (num > DEPTH || rx_buf[6] != num * 2 || len < 9 + num * 2)
            begin
                answer_exception(fn, mbrs_pkg::EXC_VALUE);
                return;
            end
            bnk = addr >> 12;
            off = addr & 12'hFFF;
            if (bnk != 0 || off + num > DEPTH)
            begin
                answer_exception(fn, mbrs_pkg::EXC_ADDRESS);
                return;
            end
            for (int i = 0; i < num; i++)
                bank_regs[off + i] = {rx_buf[7 + 2 * i], rx_buf[8 + 2 * i]};
            msg = '{station, fn, rx_buf[2], rx_buf[3], rx_buf[4], rx_buf[5]};
            answer(msg);
        end
        else
        begin
            answer_exception(fn, mbrs_pkg::EXC_FUNCTION);
        end
    endfunction

    // Advances the shadow state by one accepted request.
    function automatic void apply_request(input req_t r);
        int          len;
        logic        ovf;
        logic [15:0] crc;
        if (r.kind)
        begin
            if (r.idx < DEPTH)
                bank_regs[r.bank * DEPTH + r.idx] = r.val;
            return;
        end
        if (rx_len < BUF_BYTES)
        begin
            rx_buf[rx_len] = r.rx;
            rx_len++;
        end
        else
        begin
            rx_ovf = 1'b1;
        end
        rx_crc = crc_byte(rx_crc, r.rx);
        if (!r.fend)
            return;
        len = rx_len;
        ovf = rx_ovf;
        crc = rx_crc;
        rx_len = 0;
        rx_ovf = 1'b0;
        rx_crc = mbrs_pkg::CRC_INIT;
        decode_frame(len, ovf, crc);
    endfunction

    // Driver: presents the head of the pending queue, keeping tvalid up until
    // the request is taken, with random bursts of idling in between.
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            s_axis_tlast  <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(pending_reqs[0]);
                void'(pending_reqs.pop_front());
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (!quiet && $urandom_range(0, 7) == 0)
                    in_gap = $urandom_range(1, 7);
            end
            if ((s_axis_tvalid && !s_axis_tready) || (in_gap == 0 && pending_reqs.size() > 0))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_reqs[0].kind;
                s_axis_tlast  <= pending_reqs[0].fend;
                s_axis_tdata  <= {1'b0, pending_reqs[0].val, pending_reqs[0].idx,
                                  pending_reqs[0].bank, pending_reqs[0].rx};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each response byte and stalls at random; after the
    // fifth byte it holds off for a long stretch so that the slave backs up.
    int out_gap;
    int bytes_seen;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_gap = 0;
            bytes_seen = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                bytes_seen++;
                if (resp_due.size() == 0)
                begin
                    $error("unexpected response byte %02h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    if (m_axis_tdata !== resp_due[0].data)
                    begin
                        $error("tx_byte: expected %02h, got %02h", resp_due[0].data, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast !== resp_due[0].last)
                    begin
                        $error("tx_last: expected %0b, got %0b", resp_due[0].last, m_axis_tlast);
                        errors++;
                    end
                    void'(resp_due.pop_front());
                end
                if (bytes_seen == 5)
                    out_gap = LONG_HOLD;
            end
            if (out_gap > 0)
                out_gap--;
            else if (!quiet && $urandom_range(0, 5) == 0)
                out_gap = $urandom_range(1, 7);
            m_axis_tready <= (out_gap == 0);
        end
    end

    // Watchdog on cycles in which nothing moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("[modbus_rtu_register_slave_top] ERROR");
            $finish;
        end
    end

    task automatic queue_frame(input logic [7:0] msg[$], input bit crc_ok);
        logic [15:0] crc;
        crc = mbrs_pkg::CRC_INIT;
        foreach (msg[i])
            crc = crc_byte(crc, msg[i]);
        if (!crc_ok)
            crc = crc ^ (16'h1 << $urandom_range(0, 15));
        msg.push_back(crc[7:0]);
        msg.push_back(crc[15:8]);
        foreach (msg[i])
            pending_reqs.push_back('{1'b0, msg[i], i == msg.size() - 1, 2'd0, 5'd0, 16'd0});
        reqs_queued += msg.size();
    endtask

    task automatic queue_local(input logic [1:0] b, input logic [4:0] i, input logic [15:0] v);
        pending_reqs.push_back('{1'b1, 8'($urandom), 1'($urandom), b, i, v});
        reqs_queued++;
    endtask

    task automatic queue_read(input logic [7:0] a, input logic [7:0] fn,
                              input logic [15:0] start, input logic [15:0] num);
        queue_frame('{a, fn, start[15:8], start[7:0], num[15:8], num[7:0]}, 1'b1);
    endtask

    // Write request; data_words may differ from num to build a short frame.
    task automatic queue_write(input logic [7:0] a, input logic [15:0] start,
                               input logic [15:0] num, input logic [7:0] count_byte,
                               input int data_words, input bit crc_ok);
        logic [7:0] msg[$];
        msg = '{a, mbrs_pkg::FN_WRITE_MULT, start[15:8], start[7:0], num[15:8], num[7:0],
                count_byte};
        for (int i = 0; i < 2 * data_words; i++)
            msg.push_back(8'($urandom));
        queue_frame(msg, crc_ok);
    endtask

    // A mostly well-formed request with random content; some are foreign,
    // corrupted, truncated or plain noise.
    task automatic queue_random_request();
        logic [7:0]  a, fn, msg[$];
        logic [15:0] start, num;
        int          pick, words;
        a = ($urandom_range(0, 9) == 0) ? 8'($urandom) : station;
        pick = $urandom_range(0, 19);
        if (pick < 7)
            fn = mbrs_pkg::FN_READ_HOLD;
        else if (pick < 11)
            fn = mbrs_pkg::FN_READ_INPUT;
        else if (pick < 17)
            fn = mbrs_pkg::FN_WRITE_MULT;
        else
            fn = 8'($urandom);
        start[15:12] = ($urandom_range(0, 9) == 0) ? 4'($urandom) :
                       (fn == mbrs_pkg::FN_WRITE_MULT && $urandom_range(0, 3) != 0) ? 4'd0 :
                       4'($urandom_range(0, 3));
        start[11:0]  = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 21));
        num = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'($urandom_range(0, 21));
        if (fn == mbrs_pkg::FN_WRITE_MULT)
        begin
            words = (num > 21) ? $urandom_range(0, 3) : num;
            if ($urandom_range(0, 9) == 0 && words > 0)
                words--;
            queue_write(a, start, num,
                        ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(num * 2),
                        words, $urandom_range(0, 9) != 0);
        end
        else if ($urandom_range(0, 14) == 0)
        begin
            for (int i = $urandom_range(0, 5); i > 0; i--)
                msg.push_back(8'($urandom));
            msg.push_front(fn);
            msg.push_front(a);
            queue_frame(msg, $urandom_range(0, 1));
        end
        else
        begin
            msg = '{a, fn, start[15:8], start[7:0], num[15:8], num[7:0]};
            queue_frame(msg, $urandom_range(0, 9) != 0);
        end
        if ($urandom_range(0, 2) == 0)
            queue_local(2'($urandom), 5'($urandom), 16'($urandom));
    endtask

    // Waits for the slave to drain, then lets its decode run out.
    task automatic settle();
        wait (pending_reqs.size() == 0 && resp_due.size() == 0);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic set_station(input logic [7:0] a);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        station = a;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        errors = 0;
        reqs_queued = 0;
        quiet = 1'b0;
        idle_cycles = 0;
        station = 8'd1;
        rx_len = 0;
        rx_ovf = 1'b0;
        rx_crc = mbrs_pkg::CRC_INIT;
        foreach (bank_regs[i])
            bank_regs[i] = 16'h0000;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the station at its reset address.
        queue_local(2'd1, 5'd0, 16'hFFFF);
        queue_local(2'd3, 5'd19, 16'hA55A);
        queue_local(2'd2, 5'd31, 16'h1234);
        queue_read(8'd1, mbrs_pkg::FN_READ_INPUT, 16'h1000, 16'd20);
        queue_read(8'd1, mbrs_pkg::FN_READ_HOLD, 16'h3013, 16'd1);
        queue_read(8'd1, mbrs_pkg::FN_READ_HOLD, 16'h0000, 16'd0);
        queue_read(8'd1, mbrs_pkg::FN_READ_HOLD, 16'h0000, 16'd21);
        queue_read(8'd1, mbrs_pkg::FN_READ_HOLD, 16'hF000, 16'd1);
        queue_read(8'd1, mbrs_pkg::FN_READ_INPUT, 16'h2010, 16'd11);
        queue_write(8'd1, 16'h0005, 16'd2, 8'd4, 2, 1'b1);
        queue_read(8'd1, mbrs_pkg::FN_READ_HOLD, 16'h0004, 16'd4);
        queue_write(8'd1, 16'h1000, 16'd1, 8'd2, 1, 1'b1);
        queue_write(8'd1, 16'h0000, 16'd2, 8'd5, 2, 1'b1);
        queue_write(8'd1, 16'h0000, 16'd3, 8'd6, 2, 1'b1);
        queue_write(8'd1, 16'h0000, 16'd0, 8'd0, 0, 1'b1);
        queue_frame('{8'd1, 8'h07, 8'h00, 8'h00}, 1'b1);
        queue_read(8'd2, mbrs_pkg::FN_READ_HOLD, 16'h0000, 16'd1);
        queue_frame('{8'd1, mbrs_pkg::FN_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0);
        queue_frame('{8'd1}, 1'b1);
        queue_frame('{8'd1, mbrs_pkg::FN_READ_HOLD, 8'h00, 8'h00, 8'h01}, 1'b1);
        settle();

        // Random requests at the highest station address.
        set_station(8'd247);
        while (reqs_queued < 170)
            queue_random_request();
        settle();

        set_station(8'($urandom_range(2, 246)));
        while (reqs_queued < 195)
            queue_random_request();
        settle();

        // Closing phase back at the lowest address, with no idling.
        set_station(8'd1);
        quiet = 1'b1;
        while (reqs_queued < 220)
            queue_random_request();
        settle();

        if (errors == 0)
            $display("[modbus_rtu_register_slave_top] OK");
        else
            $display("[modbus_rtu_register_slave_top] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/mbrs_pkg.sv
rtl/core/mbrs_ctrl.sv
rtl/core/mbrs_dp.sv
rtl/core/modbus_rtu_register_slave_top.sv
test/tb_top.sv
